// ===== design/dks_pkg.sv =====
// dks_pkg: shared types, mode codes and keyword table of the keyword scanner
package dks_pkg;

  localparam int KwCount  = 13;
  localparam int KwMaxLen = 13;
  localparam int KwBits   = 8 * KwMaxLen;
  localparam int IdentMax = 127;

  localparam logic [6:0]         IdentMaxLen = 7'(IdentMax);
  localparam logic [KwCount-1:0] MaskAll     = '1;

  // scan modes
  localparam logic [2:0] ModeIdle    = 3'd0;
  localparam logic [2:0] ModeSlash   = 3'd1;
  localparam logic [2:0] ModeComment = 3'd2;
  localparam logic [2:0] ModeIdent   = 3'd3;
  localparam logic [2:0] ModeNumber  = 3'd4;
  localparam logic [2:0] ModeString  = 3'd5;
  localparam logic [2:0] ModeEsc     = 3'd6;
  localparam logic [2:0] ModeError   = 3'd7;

  // result status codes
  localparam logic [1:0] StatusScan  = 2'd0;
  localparam logic [1:0] StatusDone  = 2'd1;
  localparam logic [1:0] StatusError = 2'd2;

  // keyword text, right justified in each entry
  localparam logic [KwBits-1:0] KwText [KwCount] = '{
    KwBits'("point"), KwBits'("line"), KwBits'("circle"),
    KwBits'("segment"), KwBits'("ray"), KwBits'("parallel"),
    KwBits'("perpendicular"), KwBits'("intersect"),
    KwBits'("midpoint"), KwBits'("constraint"), KwBits'("prove"),
    KwBits'("let"), KwBits'("assert")
  };

  localparam logic [6:0] KwLen [KwCount] = '{
    7'd5, 7'd4, 7'd6, 7'd7, 7'd3, 7'd8, 7'd13, 7'd9, 7'd8, 7'd10, 7'd5, 7'd3, 7'd6
  };

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic [15:0] keyword_count;
    logic [1:0]  status;
    logic [7:0]  bad_char;
    logic        source_done;
  } result_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic [6:0]         ident_len;
    logic [KwCount-1:0] match_mask;
    logic [15:0]        count;
    logic [7:0]         error_byte;
  } scan_state_t;

  localparam scan_state_t ScanStateReset = '{
    mode:       ModeIdle,
    ident_len:  7'd0,
    match_mask: MaskAll,
    count:      16'd0,
    error_byte: 8'd0
  };

  // character of keyword k at position pos, zero beyond its end
  function automatic logic [7:0] kw_char(input int k, input logic [3:0] pos);
    logic [7:0] ch;
    ch = 8'd0;
    if (7'(pos) < KwLen[k]) begin
      ch = KwText[k][8*(int'(KwLen[k]) - 1 - int'(pos)) +: 8];
    end
    return ch;
  endfunction

endpackage

// ===== design/dks_if.sv =====
// dks_in_if / dks_out_if: valid-ready channels for source bytes and results
interface dks_in_if;
  import dks_pkg::*;

  logic valid;
  logic ready;
  in_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface dks_out_if;
  import dks_pkg::*;

  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/dks_step.sv =====
// dks_step: next scan state and result for one source byte
module dks_step (
  input  dks_pkg::scan_state_t state_i,
  input  dks_pkg::in_t         data_i,
  output dks_pkg::scan_state_t state_o,
  output dks_pkg::result_t     result_o
);
  import dks_pkg::*;

  logic [7:0]         c;
  logic               last;
  logic               is_letter, is_digit, is_space, is_ident, is_num, is_sep, is_start;
  logic [2:0]         disp_mode;
  logic               do_disp;
  logic               cont_ident, add, close_prev, at_max, fin, hit;
  logic [6:0]         add_len, new_len, fin_len;
  logic [KwCount-1:0] add_mask, step_match, new_mask, fin_mask, len_eq;
  logic [2:0]         mode_n;
  logic [6:0]         len_n;
  logic [KwCount-1:0] mask_n;
  logic [15:0]        count_n;
  logic [7:0]         err_n;

  assign c    = data_i.char_code;
  assign last = data_i.last_char;

  assign is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  assign is_digit  = c >= "0" && c <= "9";
  assign is_space  = c == " " || (c >= 8'd9 && c <= 8'd13);
  assign is_ident  = is_letter || is_digit || c == "_" || c == "-";
  assign is_num    = is_digit || c == ".";
  assign is_start  = is_letter || c == "_";
  assign is_sep    = c == ";" || c == "{" || c == "}" || c == "(" || c == ")" ||
                     c == "," || c == "=" || c == ":" || c == "+" || c == "-" ||
                     c == "*";

  // fresh dispatch of a byte at top level
  always_comb begin
    priority if (is_space) begin
      disp_mode = ModeIdle;
    end else if (c == "/") begin
      disp_mode = ModeSlash;
    end else if (is_start) begin
      disp_mode = ModeIdent;
    end else if (is_sep) begin
      disp_mode = ModeIdle;
    end else if (is_num) begin
      disp_mode = ModeNumber;
    end else if (c == "\"") begin
      disp_mode = ModeString;
    end else begin
      disp_mode = ModeError;
    end
  end

  always_comb begin
    unique case (state_i.mode)
      ModeIdle:   do_disp = 1'b1;
      ModeSlash:  do_disp = c != "/";
      ModeIdent:  do_disp = !is_ident;
      ModeNumber: do_disp = !is_num;
      default:    do_disp = 1'b0;
    endcase
  end

  assign cont_ident = state_i.mode == ModeIdent && is_ident;
  assign close_prev = state_i.mode == ModeIdent && !is_ident;
  assign add        = cont_ident || (do_disp && is_start);
  assign add_len    = cont_ident ? state_i.ident_len : 7'd0;
  assign add_mask   = cont_ident ? state_i.match_mask : MaskAll;

  // parallel keyword compare
  always_comb begin
    for (int k = 0; k < KwCount; k++) begin
      step_match[k] = (add_len < KwLen[k]) && (kw_char(k, add_len[3:0]) == c);
    end
  end

  assign new_mask = add_mask & step_match;
  assign new_len  = add_len + 7'd1;
  assign at_max   = new_len >= IdentMaxLen;

  assign fin      = close_prev || (add && (at_max || last));
  assign fin_len  = close_prev ? state_i.ident_len : new_len;
  assign fin_mask = close_prev ? state_i.match_mask : new_mask;

  always_comb begin
    for (int k = 0; k < KwCount; k++) begin
      len_eq[k] = fin_len == KwLen[k];
    end
  end

  assign hit     = fin && |(fin_mask & len_eq);
  assign count_n = (hit && state_i.count != 16'hFFFF) ? state_i.count + 16'd1
                                                      : state_i.count;

  always_comb begin
    unique case (state_i.mode)
      ModeIdle:    mode_n = disp_mode;
      ModeSlash:   mode_n = (c == "/") ? ModeComment : disp_mode;
      ModeComment: mode_n = (c == 8'd10) ? ModeIdle : ModeComment;
      ModeIdent:   mode_n = is_ident ? (at_max ? ModeIdle : ModeIdent) : disp_mode;
      ModeNumber:  mode_n = is_num ? ModeNumber : disp_mode;
      ModeString: begin
        priority if (c == "\\") begin
          mode_n = ModeEsc;
        end else if (c == "\"") begin
          mode_n = ModeIdle;
        end else begin
          mode_n = ModeString;
        end
      end
      ModeEsc:     mode_n = ModeString;
      ModeError:   mode_n = ModeError;
    endcase
  end

  always_comb begin
    priority if (fin) begin
      len_n  = 7'd0;
      mask_n = MaskAll;
    end else if (add) begin
      len_n  = new_len;
      mask_n = new_mask;
    end else begin
      len_n  = state_i.ident_len;
      mask_n = state_i.match_mask;
    end
  end

  assign err_n = (do_disp && disp_mode == ModeError) ? c : state_i.error_byte;

  always_comb begin
    result_o.keyword_count = count_n;
    result_o.bad_char      = err_n;
    result_o.source_done   = last;
    priority if (mode_n == ModeError) begin
      result_o.status = StatusError;
    end else if (last) begin
      result_o.status = StatusDone;
    end else begin
      result_o.status = StatusScan;
    end
  end

  always_comb begin
    if (last) begin
      state_o = ScanStateReset;
    end else begin
      state_o.mode       = mode_n;
      state_o.ident_len  = len_n;
      state_o.match_mask = mask_n;
      state_o.count      = count_n;
      state_o.error_byte = err_n;
    end
  end

endmodule

// ===== design/dsl_keyword_scanner.sv =====
// dsl_keyword_scanner: byte-stream keyword counter with lexical error detection
//
// Input channel in_i carries one source byte per transfer plus a flag that marks
// the final byte of a source text. Output channel out_o returns one result per
// byte: the saturating keyword count so far, the scan status, the offending byte
// of an error and a copy of the final-byte flag.
// The byte is held in an input register; the mode update and the parallel
// compare against all thirteen keywords run from it into the result register,
// which drives out_o. Throughput is one byte per cycle while out_o is taken,
// bounded by the mode and keyword-mask update that each byte depends on.
// Reset clears the scan state, the count and both stages; the first byte after
// reset starts a new source text. After the final byte the scan state returns
// to its reset value. When the receiver stalls, the result register holds and
// the input register fills, then in_i.ready drops until out_o is taken.
module dsl_keyword_scanner (
  input logic      clk_i,
  input logic      rst_ni,
  dks_in_if.sink   in_i,
  dks_out_if.source out_o
);
  import dks_pkg::*;

  logic        s1_valid_q;
  in_t         s1_data_q;
  logic        s1_adv;
  scan_state_t state_q;
  scan_state_t state_d;
  result_t     res_d;
  logic        out_valid_q;
  result_t     out_data_q;

  assign s1_adv     = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_adv;

  dks_step u_step (
    .state_i  (state_q),
    .data_i   (s1_data_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= ScanStateReset;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
        if (s1_valid_q) begin
          state_q <= state_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_data_q <= in_i.payload;
    end
    if (s1_adv && s1_valid_q) begin
      out_data_q <= res_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_data_q;

endmodule

// ===== design/dks_checker.sv =====
// dks_checker: port-level assertions for the keyword scanner, bound to the top
module dks_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input dks_pkg::result_t out_payload_i
);
  import dks_pkg::*;

  logic        xfer;
  logic        open_q;
  logic        err_open_q;
  logic [15:0] cnt_q;

  assign xfer = out_valid_i && out_ready_i;

  // track the source text in progress across result transfers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q     <= 1'b0;
      err_open_q <= 1'b0;
      cnt_q      <= 16'd0;
    end else if (xfer) begin
      open_q     <= !out_payload_i.source_done;
      err_open_q <= !out_payload_i.source_done && out_payload_i.status == StatusError;
      cnt_q      <= out_payload_i.keyword_count;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i))
    else $error("result changed while stalled");

  a_status_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_payload_i.status == StatusError) ||
                    ((out_payload_i.status == StatusDone) == out_payload_i.source_done))
    else $error("status disagrees with final-byte flag");

  a_bad_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_payload_i.status != StatusError |-> out_payload_i.bad_char == 8'd0)
    else $error("bad byte reported without error");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && err_open_q |-> out_payload_i.status == StatusError)
    else $error("error status lost before end of source");

  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && open_q |-> out_payload_i.keyword_count >= cnt_q)
    else $error("keyword count went down within a source");

endmodule

bind dsl_keyword_scanner dks_checker u_dks_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_payload_i (out_o.payload)
);

// ===== sim/dsl_keyword_scanner_tb.sv =====
// dsl_keyword_scanner_tb: self-checking bench that streams source texts and checks every result
module dsl_keyword_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dks_pkg::*;

  localparam int CycleLimit = 200_000;
  localparam int RandomBytes = 2000;
  localparam int MaxReports = 100;
  localparam string IdentChars =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789-";
  localparam string PunctChars = " \t\n\013\014\r;{}(),=:+-*";

  logic clk;
  logic rst_n;

  dks_in_if  src_if ();
  dks_out_if res_if ();

  dsl_keyword_scanner dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (src_if.sink),
    .out_o (res_if.source)
  );

  string kw_names [KwCount] = '{
    "point", "line", "circle", "segment", "ray", "parallel", "perpendicular",
    "intersect", "midpoint", "constraint", "prove", "let", "assert"
  };

  // scanner state mirror
  logic [2:0]         sc_mode;
  logic [6:0]         sc_len;
  logic [KwCount-1:0] sc_mask;
  logic [15:0]        sc_count;
  logic [7:0]         sc_bad;

  result_t    expected_results [$];
  logic [7:0] text_bytes [$];

  int  errors;
  int  cycle_count;
  int  bytes_sent;
  int  texts_sent;
  int  results_checked;
  int  texts_with_error;
  int  hold_req;
  bit  pace_on;
  bit  rx_free;
  int  burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------- keyword scan predictor ----------------

  function automatic void clear_scan();
    sc_mode  = ModeIdle;
    sc_len   = '0;
    sc_mask  = MaskAll;
    sc_count = '0;
    sc_bad   = '0;
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_numeric(logic [7:0] c);
    return (c >= "0" && c <= "9") || c == ".";
  endfunction

  function automatic bit is_word_char(logic [7:0] c);
    return is_alpha(c) || (c >= "0" && c <= "9") || c == "_" || c == "-";
  endfunction

  function automatic bit is_skipped(logic [7:0] c);
    case (c)
      " ", ";", "{", "}", "(", ")", ",", "=", ":", "+", "-", "*": return 1'b1;
      default: return c >= 8'd9 && c <= 8'd13;
    endcase
  endfunction

  function automatic void close_word();
    for (int k = 0; k < KwCount; k++) begin
      if (sc_mask[k] && kw_names[k].len() == int'(sc_len) && sc_count != 16'hFFFF) begin
        sc_count = sc_count + 16'd1;
      end
    end
    sc_mask = MaskAll;
    sc_len  = '0;
    sc_mode = ModeIdle;
  endfunction

  function automatic void push_word_char(logic [7:0] c);
    for (int k = 0; k < KwCount; k++) begin
      if (int'(sc_len) >= kw_names[k].len() || kw_names[k][sc_len] != c) begin
        sc_mask[k] = 1'b0;
      end
    end
    sc_len = sc_len + 7'd1;
    if (int'(sc_len) >= IdentMax) begin
      close_word();
    end
  endfunction

  function automatic void start_token(logic [7:0] c);
    sc_mode = ModeIdle;
    if (is_skipped(c)) begin
      return;
    end else if (c == "/") begin
      sc_mode = ModeSlash;
    end else if (is_alpha(c) || c == "_") begin
      sc_mode = ModeIdent;
      sc_len  = '0;
      sc_mask = MaskAll;
      push_word_char(c);
    end else if (is_numeric(c)) begin
      sc_mode = ModeNumber;
    end else if (c == "\"") begin
      sc_mode = ModeString;
    end else begin
      sc_bad  = c;
      sc_mode = ModeError;
    end
  endfunction

  function automatic result_t scan_byte(logic [7:0] c, logic last);
    result_t r;
    case (sc_mode)
      ModeSlash: begin
        if (c == "/") sc_mode = ModeComment;
        else start_token(c);
      end
      ModeComment: begin
        if (c == "\n") sc_mode = ModeIdle;
      end
      ModeIdent: begin
        if (is_word_char(c)) begin
          push_word_char(c);
        end else begin
          close_word();
          start_token(c);
        end
      end
      ModeNumber: begin
        if (!is_numeric(c)) start_token(c);
      end
      ModeString: begin
        if (c == "\\") sc_mode = ModeEsc;
        else if (c == "\"") sc_mode = ModeIdle;
      end
      ModeEsc: sc_mode = ModeString;
      ModeError: ;
      default: start_token(c);
    endcase
    if (last && sc_mode == ModeIdent) begin
      close_word();
    end
    r.keyword_count = sc_count;
    r.status        = (sc_mode == ModeError) ? StatusError : (last ? StatusDone : StatusScan);
    r.bad_char      = sc_bad;
    r.source_done   = last;
    if (last) begin
      if (sc_mode == ModeError) texts_with_error++;
      clear_scan();
    end
    return r;
  endfunction

  // ---------------- result checker ----------------

  task automatic report(string field, int want, int got);
    errors++;
    if (errors <= MaxReports) begin
      $error("%s: expected %0d, got %0d", field, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    result_t got;
    if (rst_n && res_if.valid && res_if.ready) begin
      got = res_if.payload;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= MaxReports) $error("result with nothing expected: %p", got);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (got.keyword_count !== want.keyword_count)
          report("keyword_count", want.keyword_count, got.keyword_count);
        if (got.status !== want.status) report("status", want.status, got.status);
        if (got.bad_char !== want.bad_char) report("bad_char", want.bad_char, got.bad_char);
        if (got.source_done !== want.source_done)
          report("source_done", want.source_done, got.source_done);
      end
    end
  end

  // receiver: stall pattern of its own, long hold-offs on request
  initial begin : result_sink
    int stall_pct;
    int span;
    int hold;
    stall_pct = 0;
    span = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold = hold_req;
        hold_req = 0;
        res_if.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end else begin
        if (span == 0) begin
          span = $urandom_range(16, 128);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        span--;
        res_if.ready <= rx_free || ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // ---------------- sender ----------------

  task automatic pace();
    int gap;
    if (!pace_on) return;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        src_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_byte(logic [7:0] c, logic last);
    src_if.valid   <= 1'b1;
    src_if.payload <= '{char_code: c, last_char: last};
    @(posedge clk);
    while (!src_if.ready) @(posedge clk);
    expected_results.push_back(scan_byte(c, last));
    bytes_sent++;
  endtask

  task automatic send_text();
    int n;
    n = text_bytes.size();
    for (int i = 0; i < n; i++) begin
      pace();
      send_byte(text_bytes[i], i == n - 1);
    end
    text_bytes.delete();
    texts_sent++;
  endtask

  task automatic wait_drained();
    src_if.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // ---------------- text building ----------------

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
  endfunction

  function automatic void add_word(int n);
    text_bytes.push_back(IdentChars[$urandom_range(0, 52)]);
    for (int i = 1; i < n; i++) text_bytes.push_back(IdentChars[$urandom_range(0, 63)]);
  endfunction

  function automatic void add_token();
    string kw;
    logic [7:0] c;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      add_text(kw_names[$urandom_range(0, KwCount - 1)]);
    end else if (pick < 45) begin
      kw = kw_names[$urandom_range(0, KwCount - 1)];
      if ($urandom_range(0, 1)) begin
        add_text(kw.substr(0, kw.len() - 2));
      end else begin
        add_text(kw);
        text_bytes.push_back(IdentChars[$urandom_range(0, 63)]);
      end
    end else if (pick < 60) begin
      add_word(($urandom_range(0, 49) == 0) ? $urandom_range(120, 135) : $urandom_range(1, 10));
    end else if (pick < 68) begin
      repeat ($urandom_range(1, 6)) text_bytes.push_back(IdentChars[$urandom_range(53, 63) - 0]
        == "-" ? "." : IdentChars[$urandom_range(53, 62)]);
    end else if (pick < 75) begin
      text_bytes.push_back("\"");
      repeat ($urandom_range(0, 8)) begin
        c = 8'($urandom_range(1, 255));
        if (c == "\"") c = "x";
        text_bytes.push_back(c);
        if (c == "\\") text_bytes.push_back(8'($urandom_range(1, 255)));
      end
      if ($urandom_range(0, 9) != 0) text_bytes.push_back("\"");
    end else if (pick < 81) begin
      add_text("//");
      repeat ($urandom_range(0, 10)) begin
        c = 8'($urandom_range(1, 255));
        if (c == "\n") c = 8'd11;
        text_bytes.push_back(c);
      end
      text_bytes.push_back("\n");
    end else if (pick < 86) begin
      text_bytes.push_back("/");
    end else if (pick < 96) begin
      repeat ($urandom_range(1, 4))
        text_bytes.push_back(PunctChars[$urandom_range(0, PunctChars.len() - 1)]);
    end else begin
      text_bytes.push_back(8'($urandom_range(1, 255)));
    end
  endfunction

  function automatic void build_text(int tokens);
    repeat (tokens) begin
      add_token();
      if ($urandom_range(0, 9) < 7)
        text_bytes.push_back(PunctChars[$urandom_range(0, PunctChars.len() - 1)]);
    end
  endfunction

  // ---------------- tests ----------------

  task automatic test_directed_cases();
    pace_on = 1'b1;
    // keyword, lone slash, hyphenated word, line comment
    add_text("ray/_a-9 //q\n");
    send_text();
    // number, string, escape, text ends on the backslash
    add_text("1.\"\\");
    send_text();
    // word still open at the final byte
    add_text("let");
    send_text();
    // high byte error, later bytes ignored
    text_bytes.push_back(8'hFF);
    text_bytes.push_back(8'h80);
    add_text("x");
    send_text();
    text_bytes.push_back(8'h01);
    send_text();
  endtask

  task automatic test_random_texts(int budget);
    int start;
    pace_on = 1'b1;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      build_text($urandom_range(1, 12));
      send_text();
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
  endtask

  task automatic test_input_stall();
    pace_on = 1'b0;
    wait_drained();
    hold_req = 80;
    build_text(20);
    send_text();
    wait_drained();
  endtask

  task automatic test_keyword_burst();
    pace_on = 1'b0;
    rx_free = 1'b1;
    repeat (60) begin
      send_byte("r", 1'b0);
      send_byte("a", 1'b0);
      send_byte("y", 1'b0);
      send_byte(";", 1'b0);
    end
    send_byte("l", 1'b0);
    send_byte("e", 1'b0);
    send_byte("t", 1'b1);
    texts_sent++;
    wait_drained();
    rx_free = 1'b0;
  endtask

  initial begin
    errors = 0;
    cycle_count = 0;
    bytes_sent = 0;
    texts_sent = 0;
    results_checked = 0;
    texts_with_error = 0;
    hold_req = 0;
    pace_on = 1'b0;
    rx_free = 1'b0;
    burst_left = 0;
    clear_scan();
    rst_n <= 1'b0;
    src_if.valid <= 1'b0;
    src_if.payload <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_texts(RandomBytes / 2);
    test_input_stall();
    test_keyword_burst();
    test_random_texts(RandomBytes / 2);

    wait_drained();
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) begin
      errors++;
      $error("%0d results never arrived", expected_results.size());
    end
    $display("scanned %0d bytes in %0d texts (%0d ending in error), %0d results checked",
             bytes_sent, texts_sent, texts_with_error, results_checked);
    $display("covered comments, strings, long words, stalls and back-to-back keywords");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/dks_pkg.sv
design/dks_if.sv
design/dks_step.sv
design/dsl_keyword_scanner.sv
design/dks_checker.sv
sim/dsl_keyword_scanner_tb.sv
